// File: rtl/core/jsd_pkg.sv
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared types and codes for the JSON string literal decoder.
// ----------------------------------------------------------------------------
package jsd_pkg;

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_STR      = 4'd1,
    M_UTF8     = 4'd2,
    M_ESC      = 4'd3,
    M_HEX_A    = 4'd4,
    M_WANT_BSL = 4'd5,
    M_WANT_U   = 4'd6,
    M_HEX_B    = 4'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;

  localparam logic [20:0] CP_MIN2     = 21'h00080;
  localparam logic [20:0] CP_MIN3     = 21'h00800;
  localparam logic [20:0] CP_MIN4     = 21'h10000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;
  // Top six bits of a 16-bit escape value for the high and low halves
  localparam logic [5:0]  HALF_HIGH   = 6'b110110;
  localparam logic [5:0]  HALF_LOW    = 6'b110111;

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  hex_cnt;
    logic [20:0] acc;
    logic [9:0]  high;
    logic [1:0]  seq_rem;
    logic [2:0]  seq_len;
  } jsd_state_t;

  typedef struct packed {
    logic [2:0]  cnt;
    logic [31:0] data;
    status_e     status;
  } jsd_result_t;

endpackage

// File: rtl/core/json_string_literal_decoder_core.sv
// ----------------------------------------------------------------------------
// json_string_literal_decoder_core
// Decodes a JSON string literal one byte at a time and emits UTF-8 output.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_byte_i         | sink
//  out     | out_valid_o, out_ready_i, out_count_o,    | source
//          | out_data_o, status_o                      |
//
//  One result per input byte; one byte per cycle sustained while out_ready_i takes results.
//  The input byte is registered, then decoded into the result register.
//  Reset returns the decoder to idle, waiting for an opening quote.
//  A stalled result holds the result register; the input register still takes
//  a byte while it is empty.
// ----------------------------------------------------------------------------
module json_string_literal_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_count_o,
  output logic [31:0] out_data_o,
  output logic [1:0]  status_o
);
  import jsd_pkg::*;

  logic        in_vld_q;
  logic [7:0]  byte_q;
  jsd_state_t  state_q;
  jsd_state_t  state_d;
  jsd_result_t res_d;
  jsd_result_t res_q;
  logic        out_vld_q;
  logic        advance;
  logic        fire;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = advance && in_vld_q;
  assign in_ready_o = !in_vld_q || advance;

  jsd_step u_step (
    .state_i  (state_q),
    .byte_i   (byte_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) out_vld_q <= in_vld_q;
      if (fire) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) byte_q <= in_byte_i;
    if (fire) res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_count_o = res_q.cnt;
  assign out_data_o  = res_q.data;
  assign status_o    = res_q.status;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.status != ST_BUSY) |=> (state_q == '0))
    else $error("decoder state not cleared after end of string");

  a_end_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_BUSY) |-> (out_count_o == 3'd0 && out_data_o == 32'd0))
    else $error("bytes emitted with a final status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_count_o <= 3'd4))
    else $error("output count out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("decoder state moved without a transfer");

endmodule

// File: rtl/core/jsd_step.sv
// ----------------------------------------------------------------------------
// jsd_step
// Decode one byte of JSON text against the current decoder state.
// ----------------------------------------------------------------------------
module jsd_step (
  input  jsd_pkg::jsd_state_t  state_i,
  input  logic [7:0]           byte_i,
  output jsd_pkg::jsd_state_t  state_o,
  output jsd_pkg::jsd_result_t result_o
);
  import jsd_pkg::*;

  typedef struct packed {
    logic [2:0]  cnt;
    logic [31:0] data;
  } enc_t;

  function automatic enc_t cp_to_bytes(input logic [20:0] cp);
    enc_t e;
    if (cp <= 21'h7F) begin
      e.cnt  = 3'd1;
      e.data = {11'd0, cp};
    end else if (cp <= 21'h7FF) begin
      e.cnt  = 3'd2;
      e.data = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    end else if (cp <= 21'hFFFF) begin
      e.cnt  = 3'd3;
      e.data = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    end else begin
      e.cnt  = 3'd4;
      e.data = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    end
    return e;
  endfunction

  // Bit 4 set marks a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    if (b inside {[8'h30:8'h39]}) begin
      v = {1'b0, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = 5'(b[2:0]) + 5'd9;
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  logic [4:0]  hv;
  logic [15:0] acc16;
  logic [20:0] acc_utf8;
  logic [1:0]  rem_dec;
  logic [20:0] min_cp;
  logic [20:0] pair_cp;
  logic [20:0] enc_cp;
  logic        enc_en;
  enc_t        enc;
  status_e     status;
  jsd_state_t  st_n;
  logic [2:0]  cnt;
  logic [31:0] data;

  assign hv       = hex_value(byte_i);
  assign acc16    = {state_i.acc[11:0], hv[3:0]};
  assign acc_utf8 = {state_i.acc[14:0], byte_i[5:0]};
  assign rem_dec  = state_i.seq_rem - 2'd1;
  assign pair_cp  = CP_MIN4 + {1'b0, state_i.high, acc16[9:0]};
  assign enc      = cp_to_bytes(enc_cp);

  always_comb begin
    case (state_i.seq_len)
      3'd2:    min_cp = CP_MIN2;
      3'd3:    min_cp = CP_MIN3;
      default: min_cp = CP_MIN4;
    endcase
  end

  always_comb begin
    st_n   = state_i;
    status = ST_BUSY;
    enc_en = 1'b0;
    enc_cp = '0;
    cnt    = '0;
    data   = '0;
    case (state_i.mode)
      M_STR: begin
        if (byte_i <= CTRL_MAX) begin
          status = ST_ERR;
        end else if (byte_i == CH_QUOTE) begin
          status = ST_DONE;
        end else if (byte_i[7]) begin
          if (byte_i[7:5] == 3'b110) begin
            st_n.seq_len = 3'd2;
            st_n.seq_rem = 2'd1;
            st_n.acc     = {16'd0, byte_i[4:0]};
            st_n.mode    = M_UTF8;
          end else if (byte_i[7:4] == 4'b1110) begin
            st_n.seq_len = 3'd3;
            st_n.seq_rem = 2'd2;
            st_n.acc     = {17'd0, byte_i[3:0]};
            st_n.mode    = M_UTF8;
          end else if (byte_i[7:3] == 5'b11110) begin
            st_n.seq_len = 3'd4;
            st_n.seq_rem = 2'd3;
            st_n.acc     = {18'd0, byte_i[2:0]};
            st_n.mode    = M_UTF8;
          end else begin
            status = ST_ERR;
          end
        end else if (byte_i == CH_BSLASH) begin
          st_n.mode = M_ESC;
        end else begin
          cnt  = 3'd1;
          data = {24'd0, byte_i};
        end
      end
      M_UTF8: begin
        if (byte_i[7:6] != 2'b10) begin
          status = ST_ERR;
        end else begin
          st_n.acc     = acc_utf8;
          st_n.seq_rem = rem_dec;
          if (rem_dec == 2'd0) begin
            if (acc_utf8 < min_cp || acc_utf8 > CP_MAX ||
                (acc_utf8 >= CP_SURR_LO && acc_utf8 <= CP_SURR_HI)) begin
              status = ST_ERR;
            end else begin
              enc_en       = 1'b1;
              enc_cp       = acc_utf8;
              st_n.mode    = M_STR;
              st_n.acc     = '0;
              st_n.seq_len = '0;
            end
          end
        end
      end
      M_ESC: begin
        st_n.mode = M_STR;
        cnt       = 3'd1;
        case (byte_i)
          CH_QUOTE:  data = {24'd0, CH_QUOTE};
          CH_BSLASH: data = {24'd0, CH_BSLASH};
          CH_SLASH:  data = {24'd0, CH_SLASH};
          CH_B:      data = 32'h08;
          CH_F:      data = 32'h0C;
          CH_N:      data = 32'h0A;
          CH_R:      data = 32'h0D;
          CH_T:      data = 32'h09;
          CH_U: begin
            cnt          = '0;
            st_n.mode    = M_HEX_A;
            st_n.hex_cnt = '0;
            st_n.acc     = '0;
          end
          default: status = ST_ERR;
        endcase
      end
      M_HEX_A, M_HEX_B: begin
        if (hv[4]) begin
          status = ST_ERR;
        end else begin
          st_n.acc = {5'd0, acc16};
          if (state_i.hex_cnt != 2'd3) begin
            st_n.hex_cnt = state_i.hex_cnt + 2'd1;
          end else begin
            st_n.hex_cnt = '0;
            if (state_i.mode == M_HEX_A) begin
              if (acc16 == 16'd0 || acc16[15:10] == HALF_LOW) begin
                status = ST_ERR;
              end else if (acc16[15:10] == HALF_HIGH) begin
                st_n.high = acc16[9:0];
                st_n.acc  = '0;
                st_n.mode = M_WANT_BSL;
              end else begin
                enc_en    = 1'b1;
                enc_cp    = {5'd0, acc16};
                st_n.acc  = '0;
                st_n.mode = M_STR;
              end
            end else begin
              if (acc16[15:10] != HALF_LOW) begin
                status = ST_ERR;
              end else begin
                enc_en    = 1'b1;
                enc_cp    = pair_cp;
                st_n.acc  = '0;
                st_n.high = '0;
                st_n.mode = M_STR;
              end
            end
          end
        end
      end
      M_WANT_BSL: begin
        if (byte_i == CH_BSLASH) st_n.mode = M_WANT_U;
        else status = ST_ERR;
      end
      M_WANT_U: begin
        if (byte_i == CH_U) begin
          st_n.mode    = M_HEX_B;
          st_n.hex_cnt = '0;
          st_n.acc     = '0;
        end else begin
          status = ST_ERR;
        end
      end
      default: begin
        // Idle and unused codes: wait for the opening quote
        st_n = '0;
        if (byte_i == CH_QUOTE) st_n.mode = M_STR;
        else status = ST_ERR;
      end
    endcase

    if (enc_en) begin
      cnt  = enc.cnt;
      data = enc.data;
    end
    // Any end of string drops all state and output bytes
    if (status != ST_BUSY) begin
      st_n = '0;
      cnt  = '0;
      data = '0;
    end
  end

  assign state_o         = st_n;
  assign result_o.cnt    = cnt;
  assign result_o.data   = data;
  assign result_o.status = status;

endmodule

// File: dv/tb_json_string_literal_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_json_string_literal_decoder_core
// Feeds JSON text one byte per transfer into the string decoder, with random
// gaps on the input and random stalls on the output. Each accepted byte is run
// through a bit-accurate decoder model in the scoreboard, and every result
// transfer is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_json_string_literal_decoder_core;
  import jsd_pkg::*;

  class unescape_tracker;
    mode_e       mode;
    logic [1:0]  hex_cnt;
    logic [20:0] acc;
    logic [9:0]  high;
    logic [1:0]  seq_rem;
    logic [2:0]  seq_len;

    jsd_result_t awaited[$];
    int          mismatch_count;
    int          results_seen;

    function new();
      clear();
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    function void clear();
      mode    = M_IDLE;
      hex_cnt = '0;
      acc     = '0;
      high    = '0;
      seq_rem = '0;
      seq_len = '0;
    endfunction

    function logic [2:0] pack_utf8(input logic [20:0] cp, output logic [31:0] word);
      if (cp <= 21'h7F) begin
        word = {24'd0, cp[7:0]};
        return 3'd1;
      end
      if (cp <= 21'h7FF) begin
        word = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        return 3'd2;
      end
      if (cp <= 21'hFFFF) begin
        word = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        return 3'd3;
      end
      word = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      return 3'd4;
    endfunction

    // Nibble value, bit 4 set for a non-hex byte
    function logic [4:0] nibble_of(input logic [7:0] b);
      logic [7:0] t;
      t = 8'd16;
      if (b >= "0" && b <= "9") t = b - "0";
      else if (b >= "a" && b <= "f") t = b - "a" + 8'd10;
      else if (b >= "A" && b <= "F") t = b - "A" + 8'd10;
      return t[4:0];
    endfunction

    function jsd_result_t decode_byte(input logic [7:0] b);
      jsd_result_t r;
      logic [20:0] floor_cp;
      logic [20:0] cp;
      logic [4:0]  nib;
      logic [31:0] word;
      r.cnt    = '0;
      r.data   = '0;
      r.status = ST_BUSY;
      word     = '0;
      case (mode)
        M_STR: begin
          if (b <= CTRL_MAX) r.status = ST_ERR;
          else if (b == CH_QUOTE) r.status = ST_DONE;
          else if (b[7]) begin
            if (b[7:5] == 3'b110) begin
              seq_len = 3'd2;
              acc     = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
              seq_len = 3'd3;
              acc     = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
              seq_len = 3'd4;
              acc     = {18'd0, b[2:0]};
            end else begin
              r.status = ST_ERR;
            end
            if (r.status == ST_BUSY) begin
              seq_rem = seq_len[1:0] - 2'd1;
              mode    = M_UTF8;
            end
          end else if (b == CH_BSLASH) begin
            mode = M_ESC;
          end else begin
            r.cnt  = 3'd1;
            r.data = {24'd0, b};
          end
        end
        M_UTF8: begin
          if (b[7:6] != 2'b10) begin
            r.status = ST_ERR;
          end else begin
            acc     = {acc[14:0], b[5:0]};
            seq_rem = seq_rem - 2'd1;
            if (seq_rem == 2'd0) begin
              floor_cp = (seq_len == 3'd2) ? CP_MIN2 :
                         (seq_len == 3'd3) ? CP_MIN3 : CP_MIN4;
              if (acc < floor_cp || acc > CP_MAX ||
                  (acc >= CP_SURR_LO && acc <= CP_SURR_HI)) begin
                r.status = ST_ERR;
              end else begin
                r.cnt   = pack_utf8(acc, word);
                r.data  = word;
                mode    = M_STR;
                acc     = '0;
                seq_len = '0;
              end
            end
          end
        end
        M_ESC: begin
          mode = M_STR;
          case (b)
            CH_U: begin
              mode    = M_HEX_A;
              hex_cnt = '0;
              acc     = '0;
            end
            CH_QUOTE, CH_BSLASH, CH_SLASH: r.data = {24'd0, b};
            CH_B: r.data = 32'h08;
            CH_F: r.data = 32'h0C;
            CH_N: r.data = 32'h0A;
            CH_R: r.data = 32'h0D;
            CH_T: r.data = 32'h09;
            default: r.status = ST_ERR;
          endcase
          if (mode == M_STR && r.status == ST_BUSY) r.cnt = 3'd1;
        end
        M_HEX_A, M_HEX_B: begin
          nib = nibble_of(b);
          if (nib[4]) begin
            r.status = ST_ERR;
          end else begin
            acc = {5'd0, acc[11:0], nib[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_cnt = '0;
              if (mode == M_HEX_A) begin
                if (acc == '0 || acc[15:10] == HALF_LOW) begin
                  r.status = ST_ERR;
                end else if (acc[15:10] == HALF_HIGH) begin
                  high = acc[9:0];
                  acc  = '0;
                  mode = M_WANT_BSL;
                end else begin
                  r.cnt  = pack_utf8(acc, word);
                  r.data = word;
                  acc    = '0;
                  mode   = M_STR;
                end
              end else if (acc[15:10] != HALF_LOW) begin
                r.status = ST_ERR;
              end else begin
                cp     = 21'h10000 + {1'b0, high, acc[9:0]};
                r.cnt  = pack_utf8(cp, word);
                r.data = word;
                acc    = '0;
                high   = '0;
                mode   = M_STR;
              end
            end
          end
        end
        M_WANT_BSL: begin
          if (b == CH_BSLASH) mode = M_WANT_U;
          else r.status = ST_ERR;
        end
        M_WANT_U: begin
          if (b == CH_U) begin
            mode    = M_HEX_B;
            hex_cnt = '0;
            acc     = '0;
          end else begin
            r.status = ST_ERR;
          end
        end
        default: begin
          clear();
          if (b == CH_QUOTE) mode = M_STR;
          else r.status = ST_ERR;
        end
      endcase
      // Any end of string drops all state and output
      if (r.status != ST_BUSY) begin
        clear();
        r.cnt  = '0;
        r.data = '0;
      end
      return r;
    endfunction

    function void note_byte(input logic [7:0] b);
      awaited.push_back(decode_byte(b));
    endfunction

    function void check_result(input logic [2:0] cnt, input logic [31:0] data,
                               input logic [1:0] status);
      jsd_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result %0d with no byte pending: cnt=%0d data=%h status=%0d",
                   $time, results_seen, cnt, data, status);
        mismatch_count++;
        return;
      end
      want = awaited.pop_front();
      if (cnt !== want.cnt || data !== want.data || status !== want.status) begin
        if (mismatch_count < 10)
          $display({"%0t: result %0d mismatch: expected cnt=%0d data=%h status=%0d, ",
                    "got cnt=%0d data=%h status=%0d"},
                   $time, results_seen, want.cnt, want.data, want.status,
                   cnt, data, status);
        mismatch_count++;
      end
    endfunction
  endclass

  typedef enum int {
    P_ASCII, P_ESCAPE, P_BMP, P_PAIR, P_UTF8,
    P_CTRL, P_BAD_LEAD, P_BAD_CONT, P_OVERLONG, P_UTF8_SURR, P_TOO_BIG,
    P_BAD_ESC, P_BAD_HEX, P_ZERO_ESC, P_LONE_LOW, P_BROKEN_PAIR, P_NOISE
  } piece_e;

  localparam int RANDOM_BYTES = 650;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  out_count_o;
  logic [31:0] out_data_o;
  logic [1:0]  status_o;

  logic        no_gaps;
  logic [7:0]  text_bytes[$];

  unescape_tracker board = new();

  json_string_literal_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_count_o (out_count_o),
    .out_data_o  (out_data_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
  endfunction

  function automatic bit is_hex_char(input logic [7:0] x);
    return (x >= "0" && x <= "9") || (x >= "a" && x <= "f") || (x >= "A" && x <= "F");
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] x);
    return x == CH_QUOTE || x == CH_BSLASH || x == CH_SLASH || x == CH_B || x == CH_F ||
           x == CH_N || x == CH_R || x == CH_T || x == CH_U;
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  task automatic push_escape(input logic [15:0] v);
    text_bytes.push_back(CH_BSLASH);
    text_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--) text_bytes.push_back(hex_char(v[4*i +: 4]));
  endtask

  // Encode with a forced length, so overlong and out-of-range forms come out too
  task automatic push_utf8(input logic [20:0] cp, input int len);
    case (len)
      2: text_bytes.push_back({3'b110, cp[10:6]});
      3: text_bytes.push_back({4'b1110, cp[15:12]});
      default: text_bytes.push_back({5'b11110, cp[20:18]});
    endcase
    if (len >= 4) text_bytes.push_back({2'b10, cp[17:12]});
    if (len >= 3) text_bytes.push_back({2'b10, cp[11:6]});
    text_bytes.push_back({2'b10, cp[5:0]});
  endtask

  task automatic push_piece(input piece_e kind);
    logic [7:0]  x;
    logic [20:0] cp;
    logic [15:0] v;
    int          len;
    int          cut;
    case (kind)
      P_ASCII: begin
        do x = 8'($urandom_range(8'h20, 8'h7F)); while (x == CH_QUOTE || x == CH_BSLASH);
        text_bytes.push_back(x);
      end
      P_ESCAPE: begin
        text_bytes.push_back(CH_BSLASH);
        text_bytes.push_back(pick_escape_letter());
      end
      P_BMP: begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(16'h0001, 16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: do v = 16'($urandom_range(16'h0800, 16'hFFFF)); while (v[15:11] == 5'b11011);
        endcase
        push_escape(v);
      end
      P_PAIR: begin
        push_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
        push_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
      P_UTF8: begin
        len = int'($urandom_range(2, 4));
        case (len)
          2: cp = 21'($urandom_range(21'h80, 21'h7FF));
          3: do cp = 21'($urandom_range(21'h800, 21'hFFFF)); while (cp[15:11] == 5'b11011);
          default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        push_utf8(cp, len);
      end
      P_CTRL: text_bytes.push_back(8'($urandom_range(8'h00, CTRL_MAX)));
      P_BAD_LEAD: begin
        if ($urandom_range(0, 1)) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
      P_BAD_CONT: begin
        len = int'($urandom_range(2, 4));
        push_utf8(21'($urandom_range(21'h80, 21'h7FF) << (len - 2) * 5), len);
        // Cut the sequence short and break it with a non-continuation byte
        cut = int'($urandom_range(1, len - 1));
        repeat (cut) void'(text_bytes.pop_back());
        do x = 8'($urandom_range(0, 255)); while (x[7:6] == 2'b10);
        text_bytes.push_back(x);
      end
      P_OVERLONG: begin
        len = int'($urandom_range(2, 4));
        case (len)
          2: cp = 21'($urandom_range(21'h0, 21'h7F));
          3: cp = 21'($urandom_range(21'h0, 21'h7FF));
          default: cp = 21'($urandom_range(21'h0, 21'hFFFF));
        endcase
        push_utf8(cp, len);
      end
      P_UTF8_SURR: push_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
      P_TOO_BIG: push_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      P_BAD_ESC: begin
        text_bytes.push_back(CH_BSLASH);
        do x = 8'($urandom_range(0, 255)); while (is_escape_letter(x));
        text_bytes.push_back(x);
      end
      P_BAD_HEX: begin
        // Half the time break the second escape of a pair
        if ($urandom_range(0, 1)) push_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
        text_bytes.push_back(CH_BSLASH);
        text_bytes.push_back(CH_U);
        repeat ($urandom_range(0, 3)) text_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        do x = 8'($urandom_range(0, 255)); while (is_hex_char(x));
        text_bytes.push_back(x);
      end
      P_ZERO_ESC: push_escape(16'h0000);
      P_LONE_LOW: push_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
      P_BROKEN_PAIR: begin
        push_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
        case ($urandom_range(0, 2))
          0: begin
            do x = 8'($urandom_range(0, 255)); while (x == CH_BSLASH);
            text_bytes.push_back(x);
          end
          1: begin
            text_bytes.push_back(CH_BSLASH);
            do x = 8'($urandom_range(0, 255)); while (x == CH_U);
            text_bytes.push_back(x);
          end
          default: begin
            do v = 16'($urandom_range(0, 16'hFFFF)); while (v[15:10] == HALF_LOW);
            push_escape(v);
          end
        endcase
      end
      default: text_bytes.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic build_directed();
    logic [7:0] seq[] = '{
      "x", CH_QUOTE, 8'h7F, CH_BSLASH, CH_N,
      CH_BSLASH, CH_U, "D", "8", "3", "d", CH_BSLASH, CH_U, "D", "E", "0", "0",
      8'hF4, 8'h8F, 8'hBF, 8'hBF, CH_QUOTE,
      CH_QUOTE, CTRL_MAX, CH_QUOTE, 8'h00
    };
    foreach (seq[i]) text_bytes.push_back(seq[i]);
  endtask

  task automatic build_random();
    int         start;
    int         pieces;
    bit         broken;
    logic [7:0] x;
    start = text_bytes.size();
    while (text_bytes.size() - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) begin
        do x = 8'($urandom_range(0, 255)); while (x == CH_QUOTE);
        text_bytes.push_back(x);
      end
      text_bytes.push_back(CH_QUOTE);
      pieces = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 30))
                                           : int'($urandom_range(0, 8));
      broken = 1'b0;
      for (int j = 0; j < pieces && !broken; j++) begin
        if ($urandom_range(0, 99) < 88) begin
          push_piece(piece_e'($urandom_range(P_ASCII, P_UTF8)));
        end else begin
          push_piece(piece_e'($urandom_range(P_CTRL, P_NOISE)));
          broken = 1'b1;
        end
      end
      if (!broken) text_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'h00 : CH_QUOTE);
    end
  endtask

  task automatic send_text();
    int         gap;
    logic [7:0] b;
    for (int i = 0; i < text_bytes.size(); i++) begin
      b   = text_bytes[i];
      gap = 0;
      while (!no_gaps && $urandom_range(0, 99) < 38) gap++;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= b;
      // Sample the handshake mid-cycle, the transfer lands on the next edge
      @(negedge clk_i);
      while (!in_ready_o) @(negedge clk_i);
      @(posedge clk_i);
      board.note_byte(b);
      no_gaps <= (i >= 200 && i < 360);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= no_gaps || ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        board.check_result(out_count_o, out_data_o, status_o);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    out_ready_i = 1'b0;
    no_gaps     = 1'b0;
    build_directed();
    build_random();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_text();
    while (board.awaited.size() != 0) @(posedge clk_i);
    // Catch any stray result after the last expected one
    repeat (20) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
